// File: rtl/tpmt_pkg.sv
// Shared types and constants for the transport stream PMT section parser.
// No dependencies; imported by every module of the block.
package tpmt_pkg;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_HDR   = 6'b000010,
        PH_PDESC = 6'b000100,
        PH_ENTRY = 6'b001000,
        PH_EDESC = 6'b010000,
        PH_CRC   = 6'b100000
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_ENTRY   = 2'd1;
    localparam logic [1:0] KIND_TRAILER = 2'd2;

    // Header byte positions.
    localparam logic [3:0] HB_LEN_HI  = 4'd1;
    localparam logic [3:0] HB_LEN_LO  = 4'd2;
    localparam logic [3:0] HB_PROG_HI = 4'd3;
    localparam logic [3:0] HB_PROG_LO = 4'd4;
    localparam logic [3:0] HB_VER     = 4'd5;
    localparam logic [3:0] HB_SEC     = 4'd6;
    localparam logic [3:0] HB_LAST    = 4'd7;
    localparam logic [3:0] HB_PCR_HI  = 4'd8;
    localparam logic [3:0] HB_PCR_LO  = 4'd9;
    localparam logic [3:0] HB_PIL_HI  = 4'd10;

    // Entry byte positions.
    localparam logic [2:0] EB_TYPE   = 3'd0;
    localparam logic [2:0] EB_PID_HI = 3'd1;
    localparam logic [2:0] EB_PID_LO = 3'd2;
    localparam logic [2:0] EB_EIL_HI = 3'd3;

    localparam logic [11:0] MIN_SECT_LEN  = 12'd13;
    localparam logic [11:0] ENTRY_BYTES   = 12'd5;
    localparam logic [2:0]  CRC_BYTES     = 3'd4;

    // One result item, as queued between parser and output.
    typedef struct packed {
        logic        malformed;
        logic [1:0]  kind;
        logic [31:0] section_crc;
        logic [12:0] es_pid;
        logic [7:0]  es_type;
        logic [12:0] pcr_pid;
        logic [7:0]  last_section_index;
        logic [7:0]  section_index;
        logic        current_next;
        logic [4:0]  version;
        logic [15:0] prog_num;
        logic [7:0]  tbl_id;
    } result_t;

endpackage

// File: rtl/ts_pmt_section_parser.sv
// Top level of the transport stream PMT section parser.
// Depends on tpmt_pkg, tpmt_front and tpmt_queue.
//
// Parses one PMT section fed one byte per transaction on the slave stream
// (tuser = section start, set on the table id byte) and emits a header
// result after byte 11, one result per elementary stream entry and a
// trailer carrying the unchecked CRC word; a length inconsistency gives a
// malformed trailer and the parser waits for the next section start.
// Throughput is one byte per clock while the result queue is not full: the
// front parser handles each byte in the cycle it is accepted and yields at
// most one result for it. Results go through a QUEUE_DEPTH-entry queue that
// feeds the master port, so the input keeps flowing while results wait;
// s_tready drops only when that queue is full. A completed result is written
// into the queue memory, and m_tvalid is decoded from the registered queue count.
module ts_pmt_section_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] section_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] tbl_id, [23:8] prog_num, [28:24] version,
    // [29] current_next, [37:30] section_index, [45:38] last_section_index,
    // [58:46] pcr_pid, [66:59] es_type, [79:67] es_pid,
    // [111:80] section_crc
    output logic [111:0] m_tdata,
    output logic [2:0]   m_tuser    // [1:0] kind, [2] malformed
);
    import tpmt_pkg::*;

    logic    s_accept;
    logic    res_valid;
    result_t res;
    logic    q_full;
    result_t q_out;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    // Front: byte parser.
    tpmt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_accept),
        .data_byte     (s_tdata),
        .section_start (s_tuser[0]),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Back: result queue and master port.
    tpmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_accept && res_valid),
        .push_data (res),
        .full      (q_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_out)
    );

    assign m_tdata = {q_out.section_crc, q_out.es_pid, q_out.es_type,
                      q_out.pcr_pid, q_out.last_section_index, q_out.section_index,
                      q_out.current_next, q_out.version, q_out.prog_num,
                      q_out.tbl_id};
    assign m_tuser = {q_out.malformed, q_out.kind};

    // A section start byte only restarts parsing; it never yields a result.
    a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tuser[0]) |-> !res_valid)
        else $error("result produced on a section start byte");

    // Malformed results always end the section as a trailer.
    a_malformed_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == KIND_TRAILER))
        else $error("malformed result with non-trailer kind");

    // CRC field is zero except on a well-formed trailer.
    a_crc_only_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] != KIND_TRAILER || m_tuser[2]))
            |-> (m_tdata[111:80] == 32'd0))
        else $error("CRC present on a non-trailer result");

    // Entry fields are zero on anything but an entry result.
    a_entry_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] != KIND_ENTRY) |-> (m_tdata[79:59] == 21'd0))
        else $error("entry fields present on a non-entry result");

endmodule

// File: rtl/tpmt_front.sv
// Front end: byte-level PMT section parser, one byte per cycle.
// Depends on tpmt_pkg; produces at most one result per accepted byte.
module tpmt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              section_start,
    output logic              res_valid,
    output tpmt_pkg::result_t res
);
    import tpmt_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [11:0] byte_pos_reg, byte_pos_next;
    logic [11:0] sect_len_reg, sect_len_next;
    logic [11:0] pil_reg, pil_next;
    logic [2:0]  ent_idx_reg, ent_idx_next;
    logic [11:0] desc_rem_reg, desc_rem_next;
    logic [20:0] etp_reg, etp_next;
    logic [31:0] crc_reg, crc_next;

    logic [7:0]  tid_reg, tid_next;
    logic [15:0] prog_reg, prog_next;
    logic [4:0]  ver_reg, ver_next;
    logic        cn_reg, cn_next;
    logic [7:0]  sec_reg, sec_next;
    logic [7:0]  last_reg, last_next;
    logic [12:0] pcr_reg, pcr_next;

    logic [11:0] body;
    logic [11:0] len_v;
    logic [11:0] bp_dec;
    logic [11:0] bp_left;
    logic [11:0] rem_v;
    logic [2:0]  idx_v;

    always_comb
    begin
        phase_next    = phase_reg;
        byte_pos_next = byte_pos_reg;
        sect_len_next = sect_len_reg;
        pil_next      = pil_reg;
        ent_idx_next  = ent_idx_reg;
        desc_rem_next = desc_rem_reg;
        etp_next      = etp_reg;
        crc_next      = crc_reg;
        tid_next      = tid_reg;
        prog_next     = prog_reg;
        ver_next      = ver_reg;
        cn_next       = cn_reg;
        sec_next      = sec_reg;
        last_next     = last_reg;
        pcr_next      = pcr_reg;

        body    = sect_len_reg - MIN_SECT_LEN;
        len_v   = '0;
        bp_dec  = byte_pos_reg - 12'd1;
        bp_left = '0;
        rem_v   = '0;
        idx_v   = ent_idx_reg + 3'd1;

        res_valid              = 1'b0;
        res.malformed          = 1'b0;
        res.kind               = KIND_TRAILER;
        res.section_crc        = '0;
        res.es_pid             = '0;
        res.es_type            = '0;
        res.pcr_pid            = pcr_reg;
        res.last_section_index = last_reg;
        res.section_index      = sec_reg;
        res.current_next       = cn_reg;
        res.version            = ver_reg;
        res.prog_num           = prog_reg;
        res.tbl_id             = tid_reg;

        if (accept && section_start)
        begin
            tid_next      = data_byte;
            prog_next     = '0;
            ver_next      = '0;
            cn_next       = 1'b0;
            sec_next      = '0;
            last_next     = '0;
            pcr_next      = '0;
            byte_pos_next = 12'd1;
            phase_next    = PH_HDR;
        end
        else if (accept)
        begin
            unique case (phase_reg) inside
                PH_HDR:
                begin
                    byte_pos_next = byte_pos_reg + 12'd1;
                    case (byte_pos_reg[3:0])
                        HB_LEN_HI: sect_len_next = {data_byte[3:0], 8'h00};
                        HB_LEN_LO:
                        begin
                            len_v         = {sect_len_reg[11:8], data_byte};
                            sect_len_next = len_v;
                            if (len_v < MIN_SECT_LEN)
                            begin
                                res_valid     = 1'b1;
                                res.malformed = 1'b1;
                                phase_next    = PH_IDLE;
                            end
                        end
                        HB_PROG_HI: prog_next[15:8] = data_byte;
                        HB_PROG_LO: prog_next[7:0]  = data_byte;
                        HB_VER:
                        begin
                            ver_next = data_byte[5:1];
                            cn_next  = data_byte[0];
                        end
                        HB_SEC:     sec_next  = data_byte;
                        HB_LAST:    last_next = data_byte;
                        HB_PCR_HI:  pcr_next[12:8] = data_byte[4:0];
                        HB_PCR_LO:  pcr_next[7:0]  = data_byte;
                        HB_PIL_HI:  pil_next = {data_byte[3:0], 8'h00};
                        default:
                        begin
                            // Last header byte: program info length complete.
                            len_v     = {pil_reg[11:8], data_byte};
                            pil_next  = len_v;
                            res_valid = 1'b1;
                            if (len_v > body)
                            begin
                                res.malformed = 1'b1;
                                phase_next    = PH_IDLE;
                            end
                            else
                            begin
                                res.kind      = KIND_HEADER;
                                bp_left       = body - len_v;
                                byte_pos_next = bp_left;
                                ent_idx_next  = '0;
                                if (len_v != '0)
                                begin
                                    desc_rem_next = len_v;
                                    phase_next    = PH_PDESC;
                                end
                                else
                                    phase_next = (bp_left != '0) ? PH_ENTRY : PH_CRC;
                            end
                        end
                    endcase
                end
                PH_PDESC, PH_EDESC:
                begin
                    rem_v         = desc_rem_reg - 12'd1;
                    desc_rem_next = rem_v;
                    if (rem_v == '0)
                    begin
                        ent_idx_next = '0;
                        phase_next   = (byte_pos_reg != '0) ? PH_ENTRY : PH_CRC;
                    end
                end
                PH_ENTRY:
                begin
                    if (ent_idx_reg == EB_TYPE && byte_pos_reg < ENTRY_BYTES)
                    begin
                        // Not enough bytes before the CRC for a whole entry.
                        res_valid     = 1'b1;
                        res.malformed = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        byte_pos_next = bp_dec;
                        ent_idx_next  = idx_v;
                        case (ent_idx_reg)
                            EB_TYPE:   etp_next = {data_byte, 13'd0};
                            EB_PID_HI: etp_next[12:8] = data_byte[4:0];
                            EB_PID_LO: etp_next[7:0]  = data_byte;
                            EB_EIL_HI: desc_rem_next = {data_byte[3:0], 8'h00};
                            default:
                            begin
                                rem_v         = {desc_rem_reg[11:8], data_byte};
                                desc_rem_next = rem_v;
                                res_valid     = 1'b1;
                                if (rem_v > bp_dec)
                                begin
                                    res.malformed = 1'b1;
                                    phase_next    = PH_IDLE;
                                end
                                else
                                begin
                                    res.kind      = KIND_ENTRY;
                                    res.es_type   = etp_reg[20:13];
                                    res.es_pid    = etp_reg[12:0];
                                    bp_left       = bp_dec - rem_v;
                                    byte_pos_next = bp_left;
                                    ent_idx_next  = '0;
                                    if (rem_v != '0)
                                        phase_next = PH_EDESC;
                                    else
                                        phase_next = (bp_left != '0) ? PH_ENTRY : PH_CRC;
                                end
                            end
                        endcase
                    end
                end
                PH_CRC:
                begin
                    crc_next     = {crc_reg[23:0], data_byte};
                    ent_idx_next = idx_v;
                    if (idx_v >= CRC_BYTES)
                    begin
                        res_valid       = 1'b1;
                        res.section_crc = {crc_reg[23:0], data_byte};
                        phase_next      = PH_IDLE;
                    end
                end
                PH_IDLE:
                begin
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            byte_pos_reg <= '0;
            sect_len_reg <= '0;
            pil_reg      <= '0;
            ent_idx_reg  <= '0;
            desc_rem_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            byte_pos_reg <= byte_pos_next;
            sect_len_reg <= sect_len_next;
            pil_reg      <= pil_next;
            ent_idx_reg  <= ent_idx_next;
            desc_rem_reg <= desc_rem_next;
        end
    end

    // Field captures; every one is written before it is used in a section.
    always_ff @(posedge clk)
    begin
        etp_reg  <= etp_next;
        crc_reg  <= crc_next;
        tid_reg  <= tid_next;
        prog_reg <= prog_next;
        ver_reg  <= ver_next;
        cn_reg   <= cn_next;
        sec_reg  <= sec_next;
        last_reg <= last_next;
        pcr_reg  <= pcr_next;
    end

endmodule

// File: rtl/tpmt_queue.sv
// Back end: small result queue that drives the master stream port.
// Depends on tpmt_pkg for the result type.
module tpmt_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tpmt_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output tpmt_pkg::result_t out_data
);
    import tpmt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: tb/sv/tb_pmt_section_check_pkg.sv
// Section parse checker for the PMT section parser testbench: a byte-level
// parser that predicts each result, plus the queue and compare of results.
// Depends on tpmt_pkg for result_t, phase_t and the byte position constants.
package tb_pmt_section_check_pkg;

    import tpmt_pkg::*;

    localparam int MAX_REPORTS = 10;

    class pmt_section_check;
        result_t     expected_results[$];
        int unsigned mismatches;

        // parser state
        phase_t      phase;
        logic [11:0] byte_pos;   // header byte index, then body bytes left before CRC
        logic [11:0] sect_len;
        logic [11:0] prog_info_len;
        logic [11:0] desc_left;
        logic [2:0]  entry_idx;
        logic [20:0] type_pid;   // {es_type, es_pid}
        logic [31:0] crc_word;
        result_t     hdr;        // header fields collected so far

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase         = PH_IDLE;
            byte_pos      = '0;
            sect_len      = '0;
            prog_info_len = '0;
            desc_left     = '0;
            entry_idx     = '0;
            type_pid      = '0;
            crc_word      = '0;
            hdr           = '0;
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] stype, logic [12:0] pid,
                                  logic [31:0] crc, logic mal);
            result_t r;
            r             = hdr;
            r.kind        = kind;
            r.es_type     = stype;
            r.es_pid      = pid;
            r.section_crc = crc;
            r.malformed   = mal;
            expected_results.push_back(r);
            if (mal || kind == KIND_TRAILER)
                phase = PH_IDLE;
        endfunction

        function void next_part();
            entry_idx = '0;
            phase     = (byte_pos != 0) ? PH_ENTRY : PH_CRC;
        endfunction

        // Called for every accepted input transaction.
        function void parse_byte(logic [7:0] b, logic start);
            logic [11:0] body;
            if (start)
            begin
                clear_state();
                hdr.tbl_id = b;
                byte_pos   = 12'd1;
                phase      = PH_HDR;
                return;
            end
            case (phase) inside
                PH_HDR:
                begin
                    case (byte_pos)
                        HB_LEN_HI:  sect_len = {b[3:0], 8'h00};
                        HB_LEN_LO:
                        begin
                            sect_len[7:0] = b;
                            if (sect_len < MIN_SECT_LEN)
                            begin
                                push_result(KIND_TRAILER, '0, '0, '0, 1'b1);
                                return;
                            end
                        end
                        HB_PROG_HI: hdr.prog_num[15:8] = b;
                        HB_PROG_LO: hdr.prog_num[7:0]  = b;
                        HB_VER:
                        begin
                            hdr.version      = b[5:1];
                            hdr.current_next = b[0];
                        end
                        HB_SEC:     hdr.section_index      = b;
                        HB_LAST:    hdr.last_section_index = b;
                        HB_PCR_HI:  hdr.pcr_pid[12:8]      = b[4:0];
                        HB_PCR_LO:  hdr.pcr_pid[7:0]       = b;
                        HB_PIL_HI:  prog_info_len          = {b[3:0], 8'h00};
                        default:
                        begin
                            // last header byte: program info length complete
                            body               = sect_len - MIN_SECT_LEN;
                            prog_info_len[7:0] = b;
                            if (prog_info_len > body)
                            begin
                                push_result(KIND_TRAILER, '0, '0, '0, 1'b1);
                                return;
                            end
                            byte_pos = body - prog_info_len;
                            if (prog_info_len != 0)
                            begin
                                desc_left = prog_info_len;
                                phase     = PH_PDESC;
                            end
                            else
                                next_part();
                            push_result(KIND_HEADER, '0, '0, '0, 1'b0);
                            return;
                        end
                    endcase
                    byte_pos = byte_pos + 12'd1;
                end
                PH_PDESC, PH_EDESC:
                begin
                    desc_left = desc_left - 12'd1;
                    if (desc_left == 0)
                        next_part();
                end
                PH_ENTRY:
                begin
                    if (entry_idx == EB_TYPE && byte_pos < ENTRY_BYTES)
                    begin
                        push_result(KIND_TRAILER, '0, '0, '0, 1'b1);
                        return;
                    end
                    byte_pos = byte_pos - 12'd1;
                    case (entry_idx)
                        EB_TYPE:   type_pid        = {b, 13'd0};
                        EB_PID_HI: type_pid[12:8]  = b[4:0];
                        EB_PID_LO: type_pid[7:0]   = b;
                        EB_EIL_HI: desc_left       = {b[3:0], 8'h00};
                        default:
                        begin
                            desc_left[7:0] = b;
                            if (desc_left > byte_pos)
                            begin
                                push_result(KIND_TRAILER, '0, '0, '0, 1'b1);
                                return;
                            end
                            byte_pos = byte_pos - desc_left;
                            if (desc_left != 0)
                            begin
                                entry_idx = '0;
                                phase     = PH_EDESC;
                            end
                            else
                                next_part();
                            push_result(KIND_ENTRY, type_pid[20:13], type_pid[12:0], '0, 1'b0);
                            return;
                        end
                    endcase
                    entry_idx = entry_idx + 3'd1;
                end
                PH_CRC:
                begin
                    crc_word  = {crc_word[23:0], b};
                    entry_idx = entry_idx + 3'd1;
                    if (entry_idx >= CRC_BYTES)
                        push_result(KIND_TRAILER, '0, '0, crc_word, 1'b0);
                end
                default: ;  // idle: bytes without a section start are dropped
            endcase
        endfunction

        function string describe(result_t r);
            return $sformatf({"kind=%0d mal=%0b tid=%h prog=%h ver=%h cn=%b sec=%h ",
                              "last=%h pcr=%h st=%h pid=%h crc=%h"},
                             r.kind, r.malformed, r.tbl_id, r.prog_num, r.version,
                             r.current_next, r.section_index, r.last_section_index,
                             r.pcr_pid, r.es_type, r.es_pid, r.section_crc);
        endfunction

        // Called for every accepted output transaction.
        function void check_result(logic [111:0] tdata, logic [2:0] tuser);
            result_t got;
            result_t want;
            string   bad;
            got.tbl_id             = tdata[7:0];
            got.prog_num           = tdata[23:8];
            got.version            = tdata[28:24];
            got.current_next       = tdata[29];
            got.section_index      = tdata[37:30];
            got.last_section_index = tdata[45:38];
            got.pcr_pid            = tdata[58:46];
            got.es_type            = tdata[66:59];
            got.es_pid             = tdata[79:67];
            got.section_crc        = tdata[111:80];
            got.kind               = tuser[1:0];
            got.malformed          = tuser[2];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing expected: %s", describe(got));
                return;
            end
            want = expected_results.pop_front();
            bad  = "";
            if (got.kind != want.kind)                             bad = {bad, " kind"};
            if (got.malformed != want.malformed)                   bad = {bad, " malformed"};
            if (got.tbl_id != want.tbl_id)                         bad = {bad, " tbl_id"};
            if (got.prog_num != want.prog_num)                     bad = {bad, " prog_num"};
            if (got.version != want.version)                       bad = {bad, " version"};
            if (got.current_next != want.current_next)             bad = {bad, " current_next"};
            if (got.section_index != want.section_index)           bad = {bad, " section_index"};
            if (got.last_section_index != want.last_section_index) bad = {bad, " last_section"};
            if (got.pcr_pid != want.pcr_pid)                       bad = {bad, " pcr_pid"};
            if (got.es_type != want.es_type)                       bad = {bad, " es_type"};
            if (got.es_pid != want.es_pid)                         bad = {bad, " es_pid"};
            if (got.section_crc != want.section_crc)               bad = {bad, " section_crc"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch in%s", bad);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

// File: tb/sv/tb_ts_pmt_section_parser.sv
// Top-level testbench of ts_pmt_section_parser: builds PMT section byte
// streams, drives them with bursty input and a stalling output side.
// Depends on tpmt_pkg and tb_pmt_section_check_pkg.
module tb_ts_pmt_section_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import tpmt_pkg::*;
    import tb_pmt_section_check_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // Content of the non-length bytes of a section.
    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;   // [7:0] data_byte
    logic [0:0]   s_tuser  = '0;   // [0] section_start
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [7:0] tbl_id, [23:8] prog_num, [28:24] version,
    // [29] current_next, [37:30] section_index, [45:38] last_section_index,
    // [58:46] pcr_pid, [66:59] es_type, [79:67] es_pid,
    // [111:80] section_crc
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;         // [1:0] kind, [2] malformed

    // Stimulus: {section_start, data_byte} per input transaction.
    logic [8:0]       byte_stream[$];
    int               section_bytes = 0;   // bytes of sections, noise not counted
    int unsigned      cycle_count   = 0;
    pmt_section_check section_check;

    ts_pmt_section_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [7:0] fill_byte(fill_t f);
        case (f)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Appends one section. len_field >= 0 overrides the section length field,
    // bad_esil > 0 replaces the ES info length of the last entry (its
    // descriptors are then left out), junk adds body bytes that form no entry,
    // cut > 0 keeps only the first cut bytes.
    task automatic add_section(input fill_t fill, input int n_es, input int pil_len,
                               input int max_esil, input int junk, input int len_field,
                               input int bad_esil, input int cut);
        logic [7:0]  sec_bytes[$];
        logic [7:0]  body_bytes[$];
        logic [7:0]  r;
        logic [11:0] sl;
        logic [11:0] pil_f;
        logic [11:0] eil_f;
        int          esil;
        int          n_out;
        pil_f = pil_len[11:0];
        repeat (pil_len) body_bytes.push_back(fill_byte(fill));
        for (int i = 0; i < n_es; i++)
        begin
            esil  = (bad_esil > 0 && i == n_es - 1) ? 0 : $urandom_range(0, max_esil);
            eil_f = (bad_esil > 0 && i == n_es - 1) ? bad_esil[11:0] : esil[11:0];
            repeat (3) body_bytes.push_back(fill_byte(fill));   // type, PID hi, PID lo
            r = fill_byte(fill);
            body_bytes.push_back({r[7:4], eil_f[11:8]});
            body_bytes.push_back(eil_f[7:0]);
            repeat (esil) body_bytes.push_back(fill_byte(fill));
        end
        repeat (junk) body_bytes.push_back(fill_byte(fill));
        sl = (len_field >= 0) ? len_field[11:0] : 12'(13 + body_bytes.size());

        sec_bytes.push_back(fill_byte(fill));                // table id
        r = fill_byte(fill);
        sec_bytes.push_back({r[7:4], sl[11:8]});
        sec_bytes.push_back(sl[7:0]);
        repeat (7) sec_bytes.push_back(fill_byte(fill));     // program .. PCR PID
        r = fill_byte(fill);
        sec_bytes.push_back({r[7:4], pil_f[11:8]});
        sec_bytes.push_back(pil_f[7:0]);
        foreach (body_bytes[k]) sec_bytes.push_back(body_bytes[k]);
        repeat (4) sec_bytes.push_back(fill_byte(fill));     // CRC word

        n_out = (cut > 0 && cut < sec_bytes.size()) ? cut : sec_bytes.size();
        for (int k = 0; k < n_out; k++)
            byte_stream.push_back({(k == 0), sec_bytes[k]});
        section_bytes += n_out;
    endtask

    // Bytes with no section start; dropped by an idle parser.
    task automatic add_noise(input int n);
        repeat (n) byte_stream.push_back({1'b0, 8'($urandom_range(0, 255))});
    endtask

    // Scoreboard hookup: both sides sampled at the edge, before the NBA updates.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            section_check.parse_byte(s_tdata, s_tuser[0]);
        if (rst_n && m_tvalid && m_tready)
            section_check.check_result(m_tdata, m_tuser);
    end

    // Output stall pattern, stepping through four phases: always ready, coin
    // flip, ready a quarter of the time, then long stalls that back up the result queue.
    always @(posedge clk)
    begin
        case (cycle_count[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (cycle_count[1:0] == 2'd0);
            default: m_tready <= (cycle_count[5:3] == 3'd0);
        endcase
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int idx;
        int burst;
        int gap;
        int sel;
        int n_es;
        int pil_len;

        section_check = new();

        // Directed sections.
        add_noise(2);                                          // idle bytes after reset
        add_section(FILL_ZERO, 0, 0, 0, 0, -1, 0, 0);          // minimum length, all zero
        add_section(FILL_ONES, 1, 1, 1, 0, -1, 0, 0);          // all ones, one entry
        add_section(FILL_RAND, 3, 0, 0, 0, -1, 0, 0);          // entries without descriptors
        add_section(FILL_RAND, 0, 0, 0, 0, 0, 0, 0);           // zero section length
        add_section(FILL_ONES, 0, 0, 0, 0, 12, 0, 0);          // one short of the minimum
        add_section(FILL_ONES, 0, 4095, 0, 0, 4095, 0, 12);    // program info at max
        add_section(FILL_RAND, 0, 3, 0, 0, 15, 0, 0);          // program info past the body
        add_section(FILL_RAND, 1, 0, 2, 1, -1, 0, 0);          // one stray body byte
        add_section(FILL_RAND, 0, 2, 0, 4, -1, 0, 0);          // four stray body bytes
        add_section(FILL_RAND, 1, 0, 0, 0, -1, 1, 0);          // ES info one too long
        add_section(FILL_RAND, 2, 1, 1, 0, -1, 4095, 0);       // ES info at max
        add_section(FILL_RAND, 1, 0, 0, 0, -1, 0, 6);          // restart inside header
        add_section(FILL_RAND, 0, 0, 0, 0, -1, 0, 1);          // start right after start
        add_section(FILL_RAND, 2, 0, 0, 0, -1, 0, 14);         // restart inside an entry
        add_section(FILL_RAND, 0, 0, 0, 0, -1, 0, 14);         // restart inside the CRC
        add_section(FILL_ONES, 2, 0, 2, 0, -1, 0, 0);          // CRC all ones
        add_noise(3);

        // Random sections: mostly well formed, some broken.
        while (section_bytes < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                add_noise($urandom_range(1, 3));
            sel     = $urandom_range(0, 99);
            n_es    = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
            pil_len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300)
                                                   : $urandom_range(0, 6);
            if (sel < 62)
                add_section(FILL_RAND, n_es, pil_len, $urandom_range(0, 4), 0, -1, 0, 0);
            else if (sel < 68)
                add_section(FILL_RAND, n_es, 0, 2, 0, $urandom_range(0, 12), 0, 0);
            else if (sel < 74)
            begin
                pil_len = $urandom_range(1, 8);
                add_section(FILL_RAND, 0, pil_len, 0, 0, 13 + $urandom_range(0, pil_len - 1),
                            0, 0);
            end
            else if (sel < 80)
                add_section(FILL_RAND, n_es, $urandom_range(0, 3), 2, $urandom_range(1, 4),
                            -1, 0, 0);
            else if (sel < 86)
                add_section(FILL_RAND, n_es + 1, $urandom_range(0, 3), 2, 0, -1,
                            ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                        : $urandom_range(1, 4095), 0);
            else
                add_section(FILL_RAND, n_es, $urandom_range(0, 3), 2, 0, -1, 0,
                            $urandom_range(1, 40));
        end

        // Reset is applied once and released on a clock edge.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Sender: bursts of random length, random gaps, some bursts back to back.
        idx = 0;
        while (idx < byte_stream.size())
        begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && idx < byte_stream.size())
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= byte_stream[idx][8];
                s_tdata  <= byte_stream[idx][7:0];
                @(posedge clk);
                while (!s_tready) @(posedge clk);
                idx++;
                burst--;
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        // Drain; a missing result ends in the watchdog, an extra one counts as a mismatch.
        while (section_check.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (section_check.mismatches == 0 && !m_tvalid)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
